// ----- rtl/core/dbcs_pkg.sv -----
// Package for the DBCS byte classifier: constants, byte kind codes,
// register indexes and the structs shared by the core modules.
// No dependencies.
`default_nettype none
package dbcs_pkg;

    localparam longint unsigned MAX_STRING_LEN = 65536;
    localparam int RANGE_COUNT = 8;

    localparam int POS_W = 16;
    localparam longint unsigned BYTE_LIMIT = (MAX_STRING_LEN > 65536) ? 65536 : MAX_STRING_LEN;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(BYTE_LIMIT - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_LEAD   = 2'd1,
        KIND_TRAIL  = 2'd2
    } byte_kind_t;

    typedef enum logic [1:0] {
        REG_LEAD_A = 2'd0,
        REG_LEAD_B = 2'd1,
        REG_SEARCH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] lead_a;
        logic [63:0] lead_b;
        logic [7:0]  search;
    } cfg_t;

    typedef struct packed {
        byte_kind_t       kind;
        logic [POS_W-1:0] pos;
        logic             done;
        logic             match;
        logic             overflow;
    } qentry_t;

endpackage
`default_nettype wire

// ----- rtl/core/dbcs_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
// No dependencies.
`default_nettype none
interface dbcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_string;

    modport source (output valid, output byte_value, output end_of_string, input ready);
    modport sink (input valid, input byte_value, input end_of_string, output ready);
endinterface

interface dbcs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [15:0] byte_position;
    logic        string_done;
    logic        first_found;
    logic [15:0] first_index;
    logic        last_found;
    logic [15:0] last_index;
    logic        length_overflow;

    modport source (
        output valid, output byte_kind, output byte_position, output string_done,
        output first_found, output first_index, output last_found, output last_index,
        output length_overflow, input ready
    );
    modport sink (
        input valid, input byte_kind, input byte_position, input string_done,
        input first_found, input first_index, input last_found, input last_index,
        input length_overflow, output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/dbcs_front.sv -----
// Front end: accepts bytes, classes them, tracks position and overflow,
// and pushes one entry per byte into the queue. Uses dbcs_pkg, dbcs_in_if.
`default_nettype none
module dbcs_front
    import dbcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    dbcs_in_if.sink     byte_in,
    output logic        push_valid,
    input  wire logic   push_ready,
    output qentry_t     push_data
);

    byte_kind_t       prev_kind_reg, prev_kind_next;
    logic [POS_W-1:0] pos_count_reg, pos_count_next;
    logic             limit_hit_reg, limit_hit_next;
    logic             overflow_reg, overflow_next;

    logic             accept;
    logic             lead;
    byte_kind_t       kind;
    logic [POS_W-1:0] pos;
    logic             at_limit;
    logic             ovf;

    function automatic logic lead_match(input logic [7:0] b, input logic [63:0] ra,
                                        input logic [63:0] rb);
        logic [127:0] all;
        logic         alive;
        logic         hit;
        logic [7:0]   lo;
        logic [7:0]   hi;
        all   = {rb, ra};
        alive = 1'b1;
        hit   = 1'b0;
        for (int r = 0; r < RANGE_COUNT; r++)
        begin
            lo = all[16*r +: 8];
            hi = all[16*r+8 +: 8];
            if (lo == 8'd0 || hi == 8'd0)
                alive = 1'b0;
            if (alive && b >= lo && b <= hi)
                hit = 1'b1;
        end
        return hit;
    endfunction

    assign accept       = byte_in.valid && push_ready;
    assign byte_in.ready = push_ready;
    assign push_valid   = byte_in.valid;

    always_comb
    begin
        lead     = lead_match(byte_in.byte_value, cfg.lead_a, cfg.lead_b);
        kind     = (prev_kind_reg == KIND_LEAD) ? KIND_TRAIL : (lead ? KIND_LEAD : KIND_SINGLE);
        at_limit = !limit_hit_reg && (pos_count_reg >= POS_MAX);
        pos      = (limit_hit_reg || at_limit) ? POS_MAX : pos_count_reg;
        ovf      = overflow_reg || limit_hit_reg;

        push_data.kind     = kind;
        push_data.pos      = pos;
        push_data.done     = byte_in.end_of_string;
        push_data.match    = (kind == KIND_SINGLE) && (byte_in.byte_value == cfg.search);
        push_data.overflow = ovf;
    end

    always_comb
    begin
        prev_kind_next = prev_kind_reg;
        pos_count_next = pos_count_reg;
        limit_hit_next = limit_hit_reg;
        overflow_next  = overflow_reg;
        if (accept)
        begin
            if (byte_in.end_of_string)
            begin
                prev_kind_next = KIND_SINGLE;
                pos_count_next = '0;
                limit_hit_next = 1'b0;
                overflow_next  = 1'b0;
            end
            else
            begin
                prev_kind_next = kind;
                overflow_next  = ovf;
                if (at_limit)
                    limit_hit_next = 1'b1;
                else if (!limit_hit_reg)
                    pos_count_next = pos_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_kind_reg <= KIND_SINGLE;
            pos_count_reg <= '0;
            limit_hit_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            prev_kind_reg <= prev_kind_next;
            pos_count_reg <= pos_count_next;
            limit_hit_reg <= limit_hit_next;
            overflow_reg  <= overflow_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dbcs_queue.sv -----
// Small register queue between the front and back ends.
// Uses dbcs_pkg.
`default_nettype none
module dbcs_queue
    import dbcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire qentry_t  push_data,
    output logic          full,
    input  wire logic     pop,
    output qentry_t       pop_data,
    output logic          empty,
    output logic [QCNT_W-1:0] count
);

    qentry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ----- rtl/core/dbcs_back.sv -----
// Back end: pops queue entries, tracks first and last match of the
// string and drives the result register. Uses dbcs_pkg, dbcs_out_if.
`default_nettype none
module dbcs_back
    import dbcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire qentry_t  pop_data,
    input  wire logic     empty,
    output logic          pop,
    dbcs_out_if.source    result_out
);

    logic             first_seen_reg, first_seen_next;
    logic [POS_W-1:0] first_where_reg, first_where_next;
    logic             last_seen_reg, last_seen_next;
    logic [POS_W-1:0] last_where_reg, last_where_next;

    logic             out_valid_reg, out_valid_next;
    byte_kind_t       kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             done_reg, done_next;
    logic             ffound_reg, ffound_next;
    logic [POS_W-1:0] findex_reg, findex_next;
    logic             lfound_reg, lfound_next;
    logic [POS_W-1:0] lindex_reg, lindex_next;
    logic             ovf_reg, ovf_next;

    logic             fs;
    logic [POS_W-1:0] fw;
    logic             ls;
    logic [POS_W-1:0] lw;

    assign pop = !empty && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        fs = first_seen_reg || pop_data.match;
        fw = (!first_seen_reg && pop_data.match) ? pop_data.pos : first_where_reg;
        ls = last_seen_reg || pop_data.match;
        lw = pop_data.match ? pop_data.pos : last_where_reg;

        first_seen_next  = first_seen_reg;
        first_where_next = first_where_reg;
        last_seen_next   = last_seen_reg;
        last_where_next  = last_where_reg;

        out_valid_next = out_valid_reg && !result_out.ready;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        ffound_next    = ffound_reg;
        findex_next    = findex_reg;
        lfound_next    = lfound_reg;
        lindex_next    = lindex_reg;
        ovf_next       = ovf_reg;

        if (pop)
        begin
            out_valid_next = 1'b1;
            kind_next      = pop_data.kind;
            pos_next       = pop_data.pos;
            done_next      = pop_data.done;
            ffound_next    = pop_data.done && fs;
            findex_next    = (pop_data.done && fs) ? fw : '0;
            lfound_next    = pop_data.done && ls;
            lindex_next    = (pop_data.done && ls) ? lw : '0;
            ovf_next       = pop_data.overflow;
            if (pop_data.done)
            begin
                first_seen_next  = 1'b0;
                first_where_next = '0;
                last_seen_next   = 1'b0;
                last_where_next  = '0;
            end
            else
            begin
                first_seen_next  = fs;
                first_where_next = fw;
                last_seen_next   = ls;
                last_where_next  = lw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg  <= 1'b0;
            first_where_reg <= '0;
            last_seen_reg   <= 1'b0;
            last_where_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_seen_reg  <= first_seen_next;
            first_where_reg <= first_where_next;
            last_seen_reg   <= last_seen_next;
            last_where_reg  <= last_where_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pos_reg    <= pos_next;
        done_reg   <= done_next;
        ffound_reg <= ffound_next;
        findex_reg <= findex_next;
        lfound_reg <= lfound_next;
        lindex_reg <= lindex_next;
        ovf_reg    <= ovf_next;
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.byte_kind       = kind_reg;
    assign result_out.byte_position   = pos_reg;
    assign result_out.string_done     = done_reg;
    assign result_out.first_found     = ffound_reg;
    assign result_out.first_index     = findex_reg;
    assign result_out.last_found      = lfound_reg;
    assign result_out.last_index      = lindex_reg;
    assign result_out.length_overflow = ovf_reg;

endmodule
`default_nettype wire

// ----- rtl/core/dbcs_byte_classify_char_search.sv -----
// Result path: an accepted byte is written into the queue, and its result is loaded into the
// result register when the back end pops that queue entry.
// Throughput: one byte per cycle; the two-entry queue and the result register let
// input and output stall independently.
// Reset (rst_n low, async): lead ranges 0, search character 1, string state cleared,
// queue and result register empty. Uses dbcs_pkg, dbcs_if, front, queue, back.
`default_nettype none
module dbcs_byte_classify_char_search
    import dbcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dbcs_in_if.sink                    byte_in,
    dbcs_out_if.source                 result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t              cfg_reg, cfg_next;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    logic              push_valid;
    qentry_t           push_data;
    logic              q_full;
    logic              q_pop;
    qentry_t           q_data;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LEAD_A: cfg_next.lead_a = pwdata;
                REG_LEAD_B: cfg_next.lead_b = pwdata;
                REG_SEARCH: cfg_next.search = pwdata[7:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LEAD_A: prdata = cfg_reg.lead_a;
            REG_LEAD_B: prdata = cfg_reg.lead_b;
            REG_SEARCH: prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.search};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_a <= '0;
            cfg_reg.lead_b <= '0;
            cfg_reg.search <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dbcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (!q_full),
        .push_data  (push_data)
    );

    dbcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    dbcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (q_data),
        .empty      (q_empty),
        .pop        (q_pop),
        .result_out (result_out)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_match_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.first_found
        |-> result_out.last_found && result_out.first_index <= result_out.last_index)
        else $error("first match without consistent last match");

    a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.length_overflow |-> result_out.byte_position == POS_MAX)
        else $error("overflow reported below the position limit");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.byte_position <= POS_MAX)
        else $error("position above limit");
`endif

endmodule
`default_nettype wire
